/* hdl/gaussian_blur_5x5_rgba_macros.svh */
// Assertion macros for the 5x5 Gaussian blur block.
// Used by the port checker; depends on nothing else.
`ifndef GAUSSIAN_BLUR_5X5_RGBA_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_RGBA_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define GB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define GB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gb_pkg.sv */
// Shared types, constants and the kernel weight table of the Gaussian blur.
// No dependencies; imported by the top level and the port checker.
package gb_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int DATA_W            = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int KSIZE             = 5;
    localparam int TAPS              = KSIZE * KSIZE;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Item kinds on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [10:0] RESET_WIDTH  = 11'd1024;
    localparam logic [15:0] RESET_HEIGHT = 16'd1024;

    typedef logic [3:0] weight_t;

    // Kernel weight at row ky, column kx (0..4); symmetric, folded to a quadrant
    function automatic weight_t kernel_weight(input logic [2:0] ky, input logic [2:0] kx);
        logic [1:0] dy;
        logic [1:0] dx;
        weight_t    w;
        dy = (ky > 3'd2) ? 2'(3'd4 - ky) : ky[1:0];
        dx = (kx > 3'd2) ? 2'(3'd4 - kx) : kx[1:0];
        case ({dy, dx})
            4'b0000: w = 4'd2;
            4'b0001: w = 4'd4;
            4'b0010: w = 4'd5;
            4'b0100: w = 4'd4;
            4'b0101: w = 4'd9;
            4'b0110: w = 4'd12;
            4'b1000: w = 4'd5;
            4'b1001: w = 4'd12;
            4'b1010: w = 4'd15;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

/* hdl/gaussian_blur_5x5_rgba.sv */
// Top level of the 5x5 Gaussian blur over an RGBA raster stream.
// Holds the row store ring, tap sequencer and bit-serial divider; needs gb_pkg.
//
//  Channel  Direction  Ports                          Contents
//  s_       in         s_tvalid/s_tready/s_tdata/s_tuser  pixel or drain item
//  m_       out        m_tvalid/m_tready/m_tdata/m_tlast  blurred pixel, frame end
//  cfg_     in         cfg_valid/cfg_ready/cfg_index/cfg_data  register write
//
// An item that yields a result is accepted, then its 25 taps are read through
// the single read port of the row store, the radix-2 divider runs, and last
// the output register is loaded; an item that yields no result stays in idle.
// Reset clears control state only; the row store needs no clearing pass.
// A stalled output holds the block in its final state until m_tready.
module gaussian_blur_5x5_rgba #(
    parameter int MAX_WIDTH = gb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gb_pkg::DATA_W-1:0]     s_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                          s_tuser,  // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gb_pkg::DATA_W-1:0]     m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                          m_tlast,  // frame_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gb_pkg::*;

    localparam int DEPTH = 4 * MAX_WIDTH + 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = $clog2(2 * MAX_WIDTH + 4);
    localparam int XW    = CW + 3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TAP  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // Row store ring
    logic [DATA_W-1:0] ring_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [10:0]   width_reg, width_next;
    logic [15:0]   height_reg, height_next;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [15:0]   in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [AW-1:0] in_ptr_reg, in_ptr_next, out_ptr_reg, out_ptr_next;
    logic [LW-1:0] ahead_reg, ahead_next;
    logic [4:0]    tap_cnt_reg, tap_cnt_next;
    logic [2:0]    ky_reg, ky_next, kx_reg, kx_next;
    logic [3:0]    div_cnt_reg, div_cnt_next;
    logic          vld_d_reg, vld_d_next;
    logic          m_valid_reg, m_valid_next;

    // Datapath
    logic [AW-1:0]     rp_reg, rp_next;
    weight_t           wt_d_reg, wt_d_next;
    logic [15:0]       acc_reg [4];
    logic [15:0]       acc_next [4];
    logic [7:0]        rem_reg [4];
    logic [7:0]        rem_next [4];
    logic [7:0]        wsum_reg, wsum_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [LW-1:0] lag;
    logic          wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   rd_sum, rp_row_sum, rp_start_sum;
    logic [17:0]   ysum;
    logic [XW-1:0] xsum;
    logic          tap_in;
    logic [WW-1:0] in_col_inc, out_col_inc;
    logic          last_pix;
    logic [8:0]    trial [4];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    // Effective frame size and output lag
    always_comb begin
        if (width_reg == 11'd0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        lag   = LW'({1'b0, w_eff, 1'b0}) + LW'(2);
    end

    // Tap addressing and frame bounds
    assign rd_sum       = {1'b0, rp_reg} + (AW+1)'(kx_reg);
    assign rd_addr      = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH))
                                                     : rd_sum[AW-1:0];
    assign rp_row_sum   = {1'b0, rp_reg} + (AW+1)'(w_eff);
    assign rp_start_sum = {1'b0, out_ptr_reg} + (AW+1)'(DEPTH) - (AW+1)'(lag);
    assign ysum         = 18'(out_row_reg) + 18'(ky_reg);
    assign xsum         = XW'(out_col_reg) + XW'(kx_reg);
    assign tap_in       = (ysum >= 18'd2) && (ysum < 18'(h_eff) + 18'd2)
                       && (xsum >= XW'(2)) && (xsum < XW'(w_eff) + XW'(2));
    assign in_col_inc   = WW'(in_col_reg) + WW'(1);
    assign out_col_inc  = WW'(out_col_reg) + WW'(1);
    assign last_pix     = (out_row_reg == h_eff - 16'd1) && (out_col_inc == w_eff);

    assign wr_en = (state_reg == ST_IDLE) && s_tvalid && (s_tuser == OP_PIXEL)
                && (in_row_reg < h_eff);
    assign rd_en = (state_reg == ST_TAP) && (tap_cnt_reg < 5'(TAPS));

    // Divider trial subtraction, one quotient bit per channel
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            trial[c] = {rem_reg[c], acc_reg[c][15]};
        end
    end

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        in_ptr_next  = in_ptr_reg;
        out_ptr_next = out_ptr_reg;
        ahead_next   = ahead_reg;
        tap_cnt_next = tap_cnt_reg;
        ky_next      = ky_reg;
        kx_next      = kx_reg;
        div_cnt_next = div_cnt_reg;
        vld_d_next   = 1'b0;
        wt_d_next    = wt_d_reg;
        rp_next      = rp_reg;
        wsum_next    = wsum_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        for (int c = 0; c < 4; c++) begin
            acc_next[c] = acc_reg[c];
            rem_next[c] = rem_reg[c];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_PIXEL) begin
                        if (in_row_reg < h_eff) begin
                            in_ptr_next = (in_ptr_reg == AW'(DEPTH - 1)) ? '0
                                        : in_ptr_reg + AW'(1);
                            if (in_col_inc >= w_eff) begin
                                in_col_next = '0;
                                in_row_next = in_row_reg + 16'd1;
                            end else begin
                                in_col_next = CW'(in_col_inc);
                            end
                            if (ahead_reg >= lag) begin
                                state_next = ST_TAP;
                            end else begin
                                ahead_next = ahead_reg + LW'(1);
                            end
                        end
                    end else if ((in_row_reg >= h_eff) && (out_row_reg < h_eff)) begin
                        state_next = ST_TAP;
                    end
                end
                // Set up a tap sweep
                tap_cnt_next = '0;
                ky_next      = '0;
                kx_next      = '0;
                wsum_next    = '0;
                rp_next      = (rp_start_sum >= (AW+1)'(DEPTH))
                             ? AW'(rp_start_sum - (AW+1)'(DEPTH)) : rp_start_sum[AW-1:0];
                for (int c = 0; c < 4; c++) begin
                    acc_next[c] = '0;
                end
            end

            ST_TAP: begin
                // Accumulate the tap read last cycle
                if (vld_d_reg) begin
                    wsum_next = wsum_reg + 8'(wt_d_reg);
                    for (int c = 0; c < 4; c++) begin
                        acc_next[c] = acc_reg[c]
                                    + 16'(rd_data_reg[8*c +: 8]) * 16'(wt_d_reg);
                    end
                end
                if (tap_cnt_reg < 5'(TAPS)) begin
                    vld_d_next   = tap_in;
                    wt_d_next    = kernel_weight(ky_reg, kx_reg);
                    tap_cnt_next = tap_cnt_reg + 5'd1;
                    if (kx_reg == 3'(KSIZE - 1)) begin
                        kx_next = '0;
                        ky_next = ky_reg + 3'd1;
                        rp_next = (rp_row_sum >= (AW+1)'(DEPTH))
                                ? AW'(rp_row_sum - (AW+1)'(DEPTH)) : rp_row_sum[AW-1:0];
                    end else begin
                        kx_next = kx_reg + 3'd1;
                    end
                end else begin
                    state_next   = ST_DIV;
                    div_cnt_next = '0;
                    for (int c = 0; c < 4; c++) begin
                        rem_next[c] = '0;
                    end
                end
            end

            ST_DIV: begin
                // Restoring division, all four channels at once
                for (int c = 0; c < 4; c++) begin
                    if (trial[c] >= {1'b0, wsum_reg}) begin
                        rem_next[c] = 8'(trial[c] - {1'b0, wsum_reg});
                        acc_next[c] = {acc_reg[c][14:0], 1'b1};
                    end else begin
                        rem_next[c] = trial[c][7:0];
                        acc_next[c] = {acc_reg[c][14:0], 1'b0};
                    end
                end
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15) begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {acc_reg[3][7:0], acc_reg[2][7:0],
                                    acc_reg[1][7:0], acc_reg[0][7:0]};
                    m_last_next  = last_pix;
                    state_next   = ST_IDLE;
                    if (last_pix) begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                        in_ptr_next  = '0;
                        out_ptr_next = '0;
                        ahead_next   = '0;
                    end else begin
                        out_ptr_next = (out_ptr_reg == AW'(DEPTH - 1)) ? '0
                                     : out_ptr_reg + AW'(1);
                        if (out_col_inc >= w_eff) begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + 16'd1;
                        end else begin
                            out_col_next = CW'(out_col_inc);
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write aborts the frame
        if (cfg_valid && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)))
        begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_next = cfg_data[10:0];
            end else begin
                height_next = cfg_data;
            end
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            in_ptr_next  = '0;
            out_ptr_next = '0;
            ahead_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= RESET_WIDTH;
            height_reg  <= RESET_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            in_ptr_reg  <= '0;
            out_ptr_reg <= '0;
            ahead_reg   <= '0;
            tap_cnt_reg <= '0;
            ky_reg      <= '0;
            kx_reg      <= '0;
            div_cnt_reg <= '0;
            vld_d_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            in_ptr_reg  <= in_ptr_next;
            out_ptr_reg <= out_ptr_next;
            ahead_reg   <= ahead_next;
            tap_cnt_reg <= tap_cnt_next;
            ky_reg      <= ky_next;
            kx_reg      <= kx_next;
            div_cnt_reg <= div_cnt_next;
            vld_d_reg   <= vld_d_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rp_reg     <= rp_next;
        wt_d_reg   <= wt_d_next;
        wsum_reg   <= wsum_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        for (int c = 0; c < 4; c++) begin
            acc_reg[c] <= acc_next[c];
            rem_reg[c] <= rem_next[c];
        end
    end

    // Row store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[in_ptr_reg] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

/* hdl/gb_checker.sv */
// Port-level checker for the Gaussian blur top level, with its bind.
// Depends on gb_pkg and gaussian_blur_5x5_rgba_macros.svh.
`include "gaussian_blur_5x5_rgba_macros.svh"

module gb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gb_pkg::DATA_W-1:0]     m_tdata,
    input logic                          m_tlast
);
    import gb_pkg::*;

    // A waiting result stays offered
    `GB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A waiting result keeps its payload
    `GB_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // A new result only comes out of the compute sequence, never from idle
    `GB_ASSERT_NOW(a_rise_busy, $rose(m_tvalid), !$past(s_tready), "result appeared while idle")

    // No accepted item yields its result on the very next cycle
    `GB_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready && (s_tuser == OP_PIXEL || s_tuser == OP_DRAIN), !$rose(m_tvalid), "result too early after accept")

endmodule

bind gaussian_blur_5x5_rgba gb_checker u_gb_checker (.*);
